/* hw/rtl/lfu_pkg.sv */
// Shared types and constants for the LFU cache policy block.
package lfu_pkg;

    // Field widths
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 40;
    localparam int CAP_W   = 5;

    // Largest capacity in normal use
    localparam int CAP_MAX = 16;

    // Largest value the capacity field can hold
    localparam int CAP_FIELD_MAX = (1 << CAP_W) - 1;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request commands
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/lfu_ctrl.sv */
// Request sequencer: accept, scan the entry table, commit the update.
module lfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output lfu_pkg::t_dp_cmd o_cmd,
    input  lfu_pkg::t_dp_stat i_stat
);
    import lfu_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the current state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Choose the next state and drive the datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // wait for room in the result register
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lfu_dp.sv */
// Entry table, lookup and victim scan, update logic and result register.
module lfu_dp #(
    parameter int SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lfu_pkg::t_dp_cmd                  i_cmd,
    output lfu_pkg::t_dp_stat                 o_stat,
    input  logic                              i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_command,
    input  logic signed [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lfu_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [lfu_pkg::DATA_W-1:0] o_read_value
);
    import lfu_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam logic [CAP_W-1:0]  SLOTS_CAP = CAP_W'(SLOTS);

    // Entry table
    logic [SLOTS-1:0]   r_valid;
    logic [KEY_W-1:0]   r_key   [SLOTS];
    logic [DATA_W-1:0]  r_data  [SLOTS];
    logic [COUNT_W-1:0] r_cnt   [SLOTS];
    logic [STAMP_W-1:0] r_stamp [SLOTS];

    // Global state
    logic [CAP_W-1:0]   r_cap;
    logic [CAP_W-1:0]   r_occ;
    logic [STAMP_W-1:0] r_clock;

    // Captured request
    logic               r_req_cmd;
    logic [KEY_W-1:0]   r_req_key;
    logic [DATA_W-1:0]  r_req_value;

    // Scan results
    logic [SLOT_W-1:0]  r_idx;
    logic               r_match_vld;
    logic [SLOT_W-1:0]  r_match_idx;
    logic [DATA_W-1:0]  r_match_data;
    logic [COUNT_W-1:0] r_match_cnt;
    logic               r_free_vld;
    logic [SLOT_W-1:0]  r_free_idx;
    logic               r_best_vld;
    logic [SLOT_W-1:0]  r_best_idx;
    logic [COUNT_W-1:0] r_best_cnt;
    logic [STAMP_W-1:0] r_best_stamp;

    // Result register
    logic               r_out_valid;
    logic               r_hit;
    logic [DATA_W-1:0]  r_rdata;

    // Scan-step signals
    logic               w_cur_valid;
    logic [COUNT_W-1:0] w_cur_cnt;
    logic [STAMP_W-1:0] w_cur_stamp;
    logic               w_match_now;
    logic               w_free_now;
    logic               w_better;

    // Commit signals
    logic [CAP_W-1:0]   w_live_cap;
    logic               w_cap_on;
    logic               w_touch;
    logic               w_use_free;
    logic               w_insert;
    logic [SLOT_W-1:0]  w_wr_idx;
    logic [COUNT_W-1:0] n_cnt;

    // Look at the entry under the scan pointer
    always_comb begin
        w_cur_valid = r_valid[r_idx];
        w_cur_cnt   = r_cnt[r_idx];
        w_cur_stamp = r_stamp[r_idx];
        w_match_now = w_cur_valid && (r_key[r_idx] == r_req_key) && !r_match_vld;
        w_free_now  = !w_cur_valid && !r_free_vld;
        w_better    = w_cur_valid &&
                      (!r_best_vld || (w_cur_cnt < r_best_cnt) ||
                       ((w_cur_cnt == r_best_cnt) && (w_cur_stamp < r_best_stamp)));
    end

    // Decide what the commit writes
    always_comb begin
        w_live_cap = (r_cap > SLOTS_CAP) ? SLOTS_CAP : r_cap;
        w_cap_on   = (w_live_cap != '0);
        w_touch    = w_cap_on && r_match_vld;
        w_use_free = (r_occ < w_live_cap) && r_free_vld;
        w_insert   = w_cap_on && !r_match_vld && (r_req_cmd == CMD_PUT) &&
                     (w_use_free || r_best_vld);
        if (w_touch) begin
            w_wr_idx = r_match_idx;
        end else if (w_use_free) begin
            w_wr_idx = r_free_idx;
        end else begin
            w_wr_idx = r_best_idx;
        end
        // saturate the use count
        n_cnt = (r_match_cnt == '1) ? r_match_cnt : r_match_cnt + COUNT_W'(1);
    end

    // Control state: capacity, valid bits, occupancy, clock, scan flags, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_clock     <= '0;
            r_idx       <= '0;
            r_match_vld <= 1'b0;
            r_free_vld  <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_match_vld <= 1'b0;
                r_free_vld  <= 1'b0;
                r_best_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                if (w_match_now) begin
                    r_match_vld <= 1'b1;
                end
                if (w_free_now) begin
                    r_free_vld <= 1'b1;
                end
                if (w_better) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (w_touch || w_insert) begin
                    r_clock <= r_clock + STAMP_W'(1);
                end
                if (w_insert) begin
                    r_valid[w_wr_idx] <= 1'b1;
                    if (w_use_free) begin
                        r_occ <= r_occ + CAP_W'(1);
                    end
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request capture, scan captures, table writes, result data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_cmd   <= i_command;
            r_req_key   <= i_key;
            r_req_value <= i_value;
        end
        if (i_cmd.scan) begin
            if (w_match_now) begin
                r_match_idx  <= r_idx;
                r_match_data <= r_data[r_idx];
                r_match_cnt  <= w_cur_cnt;
            end
            if (w_free_now) begin
                r_free_idx <= r_idx;
            end
            if (w_better) begin
                r_best_idx   <= r_idx;
                r_best_cnt   <= w_cur_cnt;
                r_best_stamp <= w_cur_stamp;
            end
        end
        if (i_cmd.commit) begin
            if (w_touch) begin
                if (r_req_cmd == CMD_PUT) begin
                    r_data[w_wr_idx] <= r_req_value;
                end
                r_cnt[w_wr_idx]   <= n_cnt;
                r_stamp[w_wr_idx] <= r_clock;
            end else if (w_insert) begin
                r_key[w_wr_idx]   <= r_req_key;
                r_data[w_wr_idx]  <= r_req_value;
                r_cnt[w_wr_idx]   <= COUNT_W'(1);
                r_stamp[w_wr_idx] <= r_clock;
            end
            r_hit   <= w_touch;
            r_rdata <= (w_touch && (r_req_cmd == CMD_GET)) ? r_match_data : '0;
        end
    end

    // Status back to the controller
    assign o_stat.scan_last = (r_idx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Drive the result port
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;

endmodule

/* hw/rtl/lfu_cache_policy_top.sv */
// Top level of the LFU cache policy: sequencer plus entry datapath.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+---------------------------------
//   request   | i_in_valid / o_in_ready     | i_command, i_key, i_value
//   result    | o_out_valid / i_out_ready   | o_hit, o_read_value
//   config    | i_cfg_we (no wait)          | i_cfg_data (capacity)
//
// A request, with SLOTS = min(ENTRIES, 31), is accepted, then each table entry is
// read in turn on the single scan port, and then the update is committed.
// The capacity field tops out at 31, so slots past that are never filled.
// Reset (synchronous) clears all valid bits at once; there is no clearing pass.
// The result register lets a new request be taken while a result waits; the
// commit stalls only if the previous result has still not been taken.
module lfu_cache_policy_top #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lfu_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [lfu_pkg::DATA_W-1:0] o_read_value
);
    import lfu_pkg::*;

    localparam int SLOTS = (ENTRIES < CAP_FIELD_MAX) ? ENTRIES : CAP_FIELD_MAX;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence each request
    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // Hold the table and compute results
    lfu_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

endmodule

/* hw/rtl/lfu_chk.sv */
// Port-level checks for the LFU cache policy, bound to the top level.
module lfu_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_hit,
    input logic signed [lfu_pkg::DATA_W-1:0] o_read_value
);
    import lfu_pkg::*;

    // Come out of reset idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("not idle after reset");

    // Take one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    // Return zero data on a miss
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_read_value == '0))
        else $error("nonzero read value on a miss");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_hit) && $stable(o_read_value)))
        else $error("stalled result changed");

endmodule

bind lfu_cache_policy_top lfu_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hit        (o_hit),
    .o_read_value (o_read_value)
);
